/* sv/ffha_pkg.sv */
// ffha_pkg: sizes, header entry format, codes and helpers for the heap allocator.
// Depends on nothing; every other file imports it.
package ffha_pkg;

	localparam int HEAP_MAX_BYTES = 4096;
	localparam int WORD_BYTES     = 8;
	localparam int HEADER_BYTES   = 16;

	localparam int CFG_W  = 13;
	localparam int REQ_W  = 13;
	localparam int FOFF_W = 12;
	localparam int DOFF_W = 12;
	localparam int STAT_W = 2;

	localparam int OFF_W   = $clog2(HEAP_MAX_BYTES + 1);
	localparam int DEPTH   = (HEAP_MAX_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int STEP_W  = $clog2(DEPTH + 1);
	localparam int WORD_SH = $clog2(WORD_BYTES);
	localparam int RND_W   = REQ_W + 1;
	localparam int ALU_W   = RND_W + 1;

	localparam int MIN_HEAP = HEADER_BYTES + WORD_BYTES;
	localparam int RST_HEAP = 4096;

	localparam logic [OFF_W-1:0] LIST_END = OFF_W'(HEAP_MAX_BYTES);

	localparam logic [0:0] CMD_ALLOC = 1'b0;
	localparam logic [0:0] CMD_FREE  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_ALLOC = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FREED = 2'd2
	} status_t;

	typedef struct packed {
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] next;
	} hdr_t;

	typedef struct packed {
		logic             wr;
		logic [OFF_W-1:0] heap_bytes;
	} cfg_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             ge;
	} alu_res_t;

	typedef struct packed {
		logic              valid;
		logic [DOFF_W-1:0] data_offset;
		status_t           status;
	} res_t;

	// header byte offset to store index; out of range goes to entry 0
	function automatic logic [IDX_W-1:0] slot(input logic [ALU_W-1:0] off);
		logic [ALU_W-1:0] i;
		i = off >> WORD_SH;
		return (i < ALU_W'(DEPTH)) ? i[IDX_W-1:0] : '0;
	endfunction

	function automatic logic [OFF_W-1:0] sat_heap(input logic [CFG_W-1:0] v);
		logic [OFF_W-1:0] r;
		if (int'(v) < MIN_HEAP) begin
			r = OFF_W'(MIN_HEAP);
		end else if (int'(v) > HEAP_MAX_BYTES) begin
			r = OFF_W'(HEAP_MAX_BYTES);
		end else begin
			r = OFF_W'(v);
		end
		return r;
	endfunction

endpackage

/* sv/ffha_if.sv */
// ffha_if: valid/ready channel interfaces for requests, responses and the config write.
// Depends on ffha_pkg.
interface ffha_req_if import ffha_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [0:0]        cmd;
	logic [REQ_W-1:0]  request_bytes;
	logic [FOFF_W-1:0] free_offset;
	modport source(output valid, cmd, request_bytes, free_offset, input ready);
	modport sink(input valid, cmd, request_bytes, free_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DOFF_W-1:0] data_offset;
	logic [STAT_W-1:0] status;
	modport source(output valid, data_offset, status, input ready);
	modport sink(input valid, data_offset, status, output ready);
endinterface

interface ffha_cfg_if import ffha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

/* sv/ffha_alu.sv */
// ffha_alu: shared subtract/compare unit used by the free check, walk and fit steps of the sequencer.
// Depends on ffha_pkg.
module ffha_alu import ffha_pkg::*; (
	input  alu_op_t  op,
	output alu_res_t res
);

	assign res.diff = op.a - op.b;
	assign res.ge   = (op.a >= op.b);

endmodule

/* sv/ffha_walk.sv */
// ffha_walk: sequencer, header store and list head; walks the free list first fit.
// Depends on ffha_pkg, ffha_if and ffha_alu.
module ffha_walk import ffha_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	ffha_req_if.sink     req,
	output res_t         res,
	input  logic         res_ready
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_FREE_CHK = 10'b00_0000_0010,
		S_FREE_WR  = 10'b00_0000_0100,
		S_WALK_ADR = 10'b00_0000_1000,
		S_WALK_CHK = 10'b00_0001_0000,
		S_FIT      = 10'b00_0010_0000,
		S_SPLIT    = 10'b00_0100_0000,
		S_LINK_RD  = 10'b00_1000_0000,
		S_LINK_WR  = 10'b01_0000_0000,
		S_DONE     = 10'b10_0000_0000
	} state_t;

	state_t             state_q, state_nxt;
	logic               pend_q;
	logic [OFF_W-1:0]   head_q;
	logic [OFF_W-1:0]   cur_q;
	logic [OFF_W-1:0]   prev_q;
	logic [OFF_W-1:0]   repl_q;
	logic [STEP_W-1:0]  steps_q;
	logic [RND_W-1:0]   rnd_q;
	logic [FOFF_W-1:0]  foff_q;
	hdr_t               blk_q;
	status_t            status_q;

	hdr_t               mem [DEPTH];
	hdr_t               rd_q;
	logic               we, re;
	logic [IDX_W-1:0]   wr_idx, rd_idx;
	hdr_t               wdata;

	alu_op_t            alu_op;
	alu_res_t           alu_res;

	logic               accept;
	logic [RND_W-1:0]   rnd_sum, rnd_val;
	logic               free_ok;
	logic               walk_stop;
	logic [ALU_W-1:0]   nb;
	logic [OFF_W-1:0]   free_hdr;

	ffha_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	assign req.ready = (state_q == S_IDLE) && !pend_q && !cfg.wr;
	assign accept    = req.valid && req.ready;

	assign rnd_sum = RND_W'(req.request_bytes) + RND_W'(WORD_BYTES - 1);
	assign rnd_val = (rnd_sum < RND_W'(WORD_BYTES)) ? RND_W'(WORD_BYTES)
		: (rnd_sum & ~RND_W'(WORD_BYTES - 1));

	assign free_ok   = (foff_q >= FOFF_W'(HEADER_BYTES)) && !alu_res.ge;
	assign free_hdr  = OFF_W'(foff_q) - OFF_W'(HEADER_BYTES);
	assign walk_stop = alu_res.ge || (steps_q == STEP_W'(DEPTH));
	assign nb        = ALU_W'(cur_q) + ALU_W'(HEADER_BYTES) + ALU_W'(rnd_q);

	always_comb begin
		alu_op = '0;
		unique case (state_q)
			S_FREE_CHK: begin
				alu_op.a = ALU_W'(foff_q);
				alu_op.b = ALU_W'(cfg.heap_bytes);
			end
			S_WALK_ADR: begin
				alu_op.a = ALU_W'(cur_q);
				alu_op.b = ALU_W'(cfg.heap_bytes);
			end
			S_WALK_CHK: begin
				alu_op.a = ALU_W'(rd_q.size);
				alu_op.b = ALU_W'(rnd_q);
			end
			S_FIT: begin
				alu_op.a = ALU_W'(blk_q.size);
				alu_op.b = ALU_W'(rnd_q) + ALU_W'(HEADER_BYTES + WORD_BYTES);
			end
			default: begin
				alu_op = '0;
			end
		endcase
	end

	always_comb begin
		we     = 1'b0;
		re     = 1'b0;
		wr_idx = '0;
		rd_idx = '0;
		wdata  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (pend_q) begin
					we         = 1'b1;
					wdata.size = cfg.heap_bytes - OFF_W'(HEADER_BYTES);
					wdata.next = LIST_END;
				end
			end
			S_FREE_CHK: begin
				if (free_ok) begin
					re     = 1'b1;
					rd_idx = slot(ALU_W'(free_hdr));
				end
			end
			S_FREE_WR: begin
				we         = 1'b1;
				wr_idx     = slot(ALU_W'(cur_q));
				wdata.size = rd_q.size;
				wdata.next = head_q;
			end
			S_WALK_ADR: begin
				if (!walk_stop) begin
					re     = 1'b1;
					rd_idx = slot(ALU_W'(cur_q));
				end
			end
			S_FIT: begin
				we = 1'b1;
				if (alu_res.ge) begin
					wr_idx     = slot(nb);
					wdata.size = OFF_W'(alu_res.diff + ALU_W'(WORD_BYTES));
					wdata.next = blk_q.next;
				end else begin
					wr_idx     = slot(ALU_W'(cur_q));
					wdata.size = blk_q.size;
					wdata.next = LIST_END;
				end
			end
			S_SPLIT: begin
				we         = 1'b1;
				wr_idx     = slot(ALU_W'(cur_q));
				wdata.size = OFF_W'(rnd_q);
				wdata.next = LIST_END;
			end
			S_LINK_RD: begin
				if (prev_q != LIST_END) begin
					re     = 1'b1;
					rd_idx = slot(ALU_W'(prev_q));
				end
			end
			S_LINK_WR: begin
				we         = 1'b1;
				wr_idx     = slot(ALU_W'(prev_q));
				wdata.size = rd_q.size;
				wdata.next = repl_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx] <= wdata;
		end
		if (re) begin
			rd_q <= mem[rd_idx];
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = (req.cmd == CMD_FREE) ? S_FREE_CHK : S_WALK_ADR;
				end
			end
			S_FREE_CHK: state_nxt = free_ok ? S_FREE_WR : S_DONE;
			S_FREE_WR:  state_nxt = S_DONE;
			S_WALK_ADR: state_nxt = walk_stop ? S_DONE : S_WALK_CHK;
			S_WALK_CHK: state_nxt = alu_res.ge ? S_FIT : S_WALK_ADR;
			S_FIT:      state_nxt = alu_res.ge ? S_SPLIT : S_LINK_RD;
			S_SPLIT:    state_nxt = S_LINK_RD;
			S_LINK_RD:  state_nxt = (prev_q == LIST_END) ? S_DONE : S_LINK_WR;
			S_LINK_WR:  state_nxt = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_q   <= 1'b1;
			head_q   <= '0;
			status_q <= ST_FREED;
		end else begin
			state_q <= state_nxt;
			if (cfg.wr) begin
				pend_q <= 1'b1;
			end else if (state_q == S_IDLE && pend_q) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						head_q <= '0;
					end
				end
				S_FREE_CHK: status_q <= ST_FREED;
				S_FREE_WR:  head_q <= cur_q;
				S_WALK_ADR: begin
					if (walk_stop) begin
						status_q <= ST_NOFIT;
					end
				end
				S_LINK_RD: begin
					status_q <= ST_ALLOC;
					if (prev_q == LIST_END) begin
						head_q <= repl_q;
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					foff_q  <= req.free_offset;
					rnd_q   <= rnd_val;
					cur_q   <= head_q;
					prev_q  <= LIST_END;
					steps_q <= '0;
				end
			end
			S_FREE_CHK: begin
				if (free_ok) begin
					cur_q <= free_hdr;
				end
			end
			S_WALK_CHK: begin
				if (alu_res.ge) begin
					blk_q <= rd_q;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= rd_q.next;
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			S_FIT: begin
				repl_q <= alu_res.ge ? OFF_W'(nb) : blk_q.next;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign res.valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.data_offset = (status_q == ST_ALLOC)
		? DOFF_W'(cur_q + OFF_W'(HEADER_BYTES)) : '0;

endmodule

/* sv/first_fit_heap_allocator.sv */
// first_fit_heap_allocator: a free checks the offset and, if it is good, puts the block at the
// list head. Allocate: one store read and size check per free-list header visited, then a fit
// check, optional split, unlink and relink; next item accepted once the result is registered.
// A registered output lets the next item be taken while a response waits.
// Reset (async, arst_n low) gives heap_bytes 4096 and one free block; after reset and after
// every heap_bytes write, the first header is rewritten before an item is accepted.
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ffha_req_if.sink  req,
	ffha_rsp_if.source rsp,
	ffha_cfg_if.sink  cfg
);

	logic [OFF_W-1:0]  heap_q;
	cfg_t              wcfg;
	res_t              res;
	logic              res_ready;
	logic              out_valid_q;
	logic [DOFF_W-1:0] out_offset_q;
	status_t           out_status_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= OFF_W'(RST_HEAP);
		end else if (cfg.valid) begin
			heap_q <= sat_heap(cfg.data);
		end
	end

	assign wcfg.wr         = cfg.valid;
	assign wcfg.heap_bytes = heap_q;

	ffha_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (wcfg),
		.req       (req),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_offset_q <= res.data_offset;
			out_status_q <= res.status;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data_offset = out_offset_q;
	assign rsp.status      = out_status_q;

endmodule

/* sv/ffha_chk.sv */
// ffha_chk: port-level checks for first_fit_heap_allocator, attached by bind.
// Depends on ffha_pkg.
module ffha_chk import ffha_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DOFF_W-1:0] rsp_data_offset,
	input logic [STAT_W-1:0] rsp_status,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request channel ready right after an accepted item");

	a_init_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !req_ready)
		else $error("item accepted before header reinit");

	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_ALLOC |-> rsp_data_offset == '0)
		else $error("nonzero offset on a response that is not an allocation");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_offset)
			&& $stable(rsp_status))
		else $error("stalled response changed");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_data_offset (rsp.data_offset),
	.rsp_status      (rsp.status),
	.cfg_valid       (cfg.valid),
	.cfg_ready       (cfg.ready)
);

/* tb/sv/tb_first_fit_heap_allocator.sv */
`timescale 1ns / 100ps
// tb_first_fit_heap_allocator: drives allocate/free items and heap_bytes writes, predicts each
// response from a behavioral free-list model and checks it. Depends on ffha_pkg and ffha_if.
module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int IDLE_PCT     = 33;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [DOFF_W-1:0] offset;
		status_t           status;
	} heap_reply_t;

	logic clk;
	logic arst_n;

	ffha_req_if req();
	ffha_rsp_if rsp();
	ffha_cfg_if cfg();

	first_fit_heap_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// behavioral free list
	int unsigned blk_size [DEPTH];
	int unsigned blk_next [DEPTH];
	bit          blk_known[DEPTH];
	int unsigned list_start;
	int unsigned heap_len;

	heap_reply_t       replies_due[$];
	logic [DOFF_W-1:0] live_blocks[$];
	heap_reply_t       want;

	int errors     = 0;
	bit steady     = 1'b0;
	int stall_len  = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(100_000_000);
		$display("FAIL first_fit_heap_allocator");
		$finish;
	end

	function automatic int unsigned entry_of(input int unsigned off);
		return (off / WORD_BYTES < DEPTH) ? off / WORD_BYTES : 0;
	endfunction

	function automatic void heap_reset(input int unsigned bytes);
		if (bytes < MIN_HEAP) bytes = MIN_HEAP;
		if (bytes > HEAP_MAX_BYTES) bytes = HEAP_MAX_BYTES;
		heap_len = bytes;
		foreach (blk_known[i]) blk_known[i] = 1'b0;
		blk_size[0]  = bytes - HEADER_BYTES;
		blk_next[0]  = int'(LIST_END);
		blk_known[0] = 1'b1;
		list_start   = 0;
		live_blocks.delete();
	endfunction

	function automatic void forget_live(input int unsigned fo);
		foreach (live_blocks[i]) begin
			if (live_blocks[i] == fo) begin
				live_blocks.delete(i);
				return;
			end
		end
	endfunction

	function automatic void predict_reply(input logic [0:0] c, input int unsigned rq,
			input int unsigned fo);
		heap_reply_t r;
		int unsigned need, cur, prev, steps, tail, repl;
		bit hit;
		r.offset = '0;
		if (c == CMD_FREE) begin
			r.status = ST_FREED;
			if (fo >= HEADER_BYTES && fo < heap_len) begin
				blk_next[entry_of(fo - HEADER_BYTES)] = list_start;
				list_start = fo - HEADER_BYTES;
				forget_live(fo);
			end
		end else begin
			need = (rq + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
			if (need < WORD_BYTES) need = WORD_BYTES;
			cur   = list_start;
			prev  = int'(LIST_END);
			steps = 0;
			hit   = 1'b0;
			while (!hit && cur < heap_len && steps < DEPTH) begin
				if (blk_size[entry_of(cur)] >= need) begin
					hit = 1'b1;
				end else begin
					prev = cur;
					cur  = blk_next[entry_of(cur)];
					steps++;
				end
			end
			if (!hit) begin
				r.status = ST_NOFIT;
			end else begin
				if (blk_size[entry_of(cur)] >= need + HEADER_BYTES + WORD_BYTES) begin
					tail = cur + HEADER_BYTES + need;
					blk_size[entry_of(tail)]  = blk_size[entry_of(cur)] - need - HEADER_BYTES;
					blk_next[entry_of(tail)]  = blk_next[entry_of(cur)];
					blk_known[entry_of(tail)] = 1'b1;
					blk_size[entry_of(cur)]   = need;
					repl = tail;
				end else begin
					repl = blk_next[entry_of(cur)];
				end
				blk_next[entry_of(cur)] = int'(LIST_END);
				if (prev == int'(LIST_END)) list_start = repl;
				else blk_next[entry_of(prev)] = repl;
				r.offset = DOFF_W'(cur + HEADER_BYTES);
				r.status = ST_ALLOC;
				live_blocks.push_back(r.offset);
			end
		end
		replies_due.push_back(r);
	endfunction

	// receiver: random ready, or a held-off stretch when stall_len is set
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_len > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
				stall_len = 0;
			end else begin
				rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected item data_offset %0d status %0d", $time,
					rsp.data_offset, rsp.status);
			end else begin
				want = replies_due.pop_front();
				if (rsp.data_offset !== want.offset) begin
					errors++;
					$display("%0t: data_offset expected %0d actual %0d", $time,
						want.offset, rsp.data_offset);
				end
				if (rsp.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp.status);
				end
			end
		end
	end

	task automatic send_item(input logic [0:0] c, input int unsigned rq, input int unsigned fo);
		rq = rq & 32'h1FFF;
		fo = fo & 32'hFFF;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.cmd           <= c;
		req.request_bytes <= REQ_W'(rq);
		req.free_offset   <= FOFF_W'(fo);
		do @(posedge clk); while (!req.ready);
		predict_reply(c, rq, fo);
	endtask

	task automatic alloc_item(input int unsigned rq);
		send_item(CMD_ALLOC, rq, $urandom_range(HEAP_MAX_BYTES - 1));
	endtask

	task automatic free_item(input int unsigned fo);
		send_item(CMD_FREE, $urandom_range(HEAP_MAX_BYTES), fo);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_heap_bytes(input int unsigned v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= CFG_W'(v);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		heap_reset(v & 32'h1FFF);
	endtask

	function automatic int unsigned pick_request();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 55) return $urandom_range(64);
		if (p < 85) return $urandom_range(512, 65);
		if (p < 97) return $urandom_range(HEAP_MAX_BYTES, 513);
		return HEAP_MAX_BYTES;
	endfunction

	// offsets that free nothing: below a header, or past the heap
	function automatic int unsigned bad_offset();
		if (heap_len < HEAP_MAX_BYTES && $urandom_range(1))
			return $urandom_range(HEAP_MAX_BYTES - 1, heap_len);
		return $urandom_range(HEADER_BYTES - 1);
	endfunction

	// any written header, maybe off by a few bytes: double frees and odd alignment
	function automatic int unsigned stray_offset();
		int unsigned idx[$];
		int unsigned fo;
		for (int i = 0; i < DEPTH; i++) if (blk_known[i]) idx.push_back(i);
		fo = idx[$urandom_range(idx.size() - 1)] * WORD_BYTES + HEADER_BYTES;
		if ($urandom_range(3) == 0) fo += $urandom_range(WORD_BYTES - 1);
		return (fo < HEAP_MAX_BYTES) ? fo : 0;
	endfunction

	task automatic random_op();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 45) begin
			if (live_blocks.size() != 0)
				free_item(live_blocks[$urandom_range(live_blocks.size() - 1)]);
			else
				alloc_item(pick_request());
		end else if (p < 50) begin
			free_item(bad_offset());
		end else if (p < 53) begin
			free_item(stray_offset());
		end else begin
			alloc_item(pick_request());
		end
	endtask

	task automatic test_directed_ops();
		alloc_item(0);
		alloc_item(1);
		alloc_item(9);
		free_item(HEADER_BYTES);
		alloc_item(WORD_BYTES);
		free_item(0);
		free_item(HEADER_BYTES - 1);
		alloc_item(HEAP_MAX_BYTES);
		free_item(HEADER_BYTES);
		free_item(HEADER_BYTES);
		alloc_item(HEAP_MAX_BYTES);
		alloc_item(WORD_BYTES);
	endtask

	task automatic test_heap_limits();
		write_heap_bytes(0);
		alloc_item(WORD_BYTES);
		alloc_item(1);
		free_item(HEAP_MAX_BYTES - 1);
		free_item(MIN_HEAP);
		free_item(HEADER_BYTES);
		alloc_item(WORD_BYTES + 1);
		write_heap_bytes(32);
		alloc_item(WORD_BYTES);
		free_item(32);
		write_heap_bytes(8191);
		alloc_item(HEAP_MAX_BYTES - HEADER_BYTES);
		alloc_item(HEAP_MAX_BYTES - 23);
		free_item(HEADER_BYTES);
		alloc_item(HEAP_MAX_BYTES - 40);
		free_item(HEADER_BYTES);
		alloc_item(HEAP_MAX_BYTES - 40);
		alloc_item(WORD_BYTES);
		free_item(HEAP_MAX_BYTES - WORD_BYTES);
	endtask

	task automatic test_random_traffic(input int unsigned heap, input int n);
		write_heap_bytes(heap);
		repeat (n) random_op();
	endtask

	task automatic test_backpressure();
		drain();
		stall_len = 300;
		steady = 1'b1;
		repeat (40) random_op();
		steady = 1'b0;
	endtask

	task automatic test_steady_stream();
		steady = 1'b1;
		repeat (80) random_op();
		steady = 1'b0;
	endtask

	initial begin
		arst_n            <= 1'b0;
		req.valid         <= 1'b0;
		req.cmd           <= CMD_ALLOC;
		req.request_bytes <= '0;
		req.free_offset   <= '0;
		cfg.valid         <= 1'b0;
		cfg.data          <= '0;
		heap_reset(RST_HEAP);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_heap_limits();
		test_random_traffic(HEAP_MAX_BYTES, 200);
		test_random_traffic(32, 40);
		test_random_traffic($urandom_range(HEAP_MAX_BYTES, MIN_HEAP + WORD_BYTES), 100);
		test_random_traffic(256, 80);
		test_backpressure();
		test_steady_stream();

		drain();
		if (errors == 0) begin
			$display("PASS first_fit_heap_allocator");
		end else begin
			$display("FAIL first_fit_heap_allocator");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_alu.sv
sv/ffha_walk.sv
sv/first_fit_heap_allocator.sv
sv/ffha_chk.sv
tb/sv/tb_first_fit_heap_allocator.sv
